// ----- src/cic_pkg.sv -----
// Shared constants, types and helper functions for the cone isolation check.
package cic_pkg;

  localparam int EVENT_DEPTH = 256;
  localparam int DEPTH_W     = $clog2(EVENT_DEPTH);
  localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);
  localparam int IDX_W       = 8;
  localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int ID_W        = 24;
  localparam int PT_W        = 16;
  localparam int ETA_W       = 13;
  localparam int PHI_W       = 12;
  localparam int CUT_W       = 12;
  localparam int RAD_W       = 24;
  localparam int FRAC_W      = 12;
  localparam int FRAC_SHIFT  = 8;
  localparam int SUM_W       = 24;
  localparam int FPROD_W     = FRAC_W + PT_W;
  localparam int ISO_W       = SUM_W + FRAC_SHIFT;
  localparam int DETA_W      = ETA_W + 1;
  localparam int ADETA_W     = ETA_W;
  localparam int DETA_SQ_W   = 2 * ADETA_W;
  localparam int DPHI_SQ_W   = 2 * PHI_W;
  localparam int R2_W        = DETA_SQ_W + 1;

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_SEL_W   = ADDR_W - 2;

  localparam logic [REG_SEL_W-1:0] REG_WANTED_ID      = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_CAND_MIN_PT    = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_CAND_MAX_ETA   = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_TRACK_MAX_ETA  = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_TRACK_MIN_PT   = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_CONE_RADIUS_SQ = 3'd5;
  localparam logic [REG_SEL_W-1:0] REG_FRACTION_LIMIT = 3'd6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [ID_W-1:0] ID_NU_E       = 24'd12;
  localparam logic [ID_W-1:0] ID_NU_MU      = 24'd14;
  localparam logic [ID_W-1:0] ID_NU_TAU     = 24'd16;
  localparam logic [ID_W-1:0] ID_NEUTRALINO = 24'd1000022;
  localparam logic [ID_W-1:0] ID_DM         = 24'd8880022;

  localparam logic [PHI_W-1:0] PHI_HALF = 12'd2048;

  typedef struct packed {
    logic [ID_W-1:0]   wanted_id;
    logic [PT_W-1:0]   cand_min_pt;
    logic [CUT_W-1:0]  cand_max_eta;
    logic [CUT_W-1:0]  track_max_eta;
    logic [PT_W-1:0]   track_min_pt;
    logic [RAD_W-1:0]  cone_radius_sq;
    logic [FRAC_W-1:0] fraction_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wanted_id:      24'd11,
    cand_min_pt:    16'd0,
    cand_max_eta:   12'd1630,
    track_max_eta:  12'd3260,
    track_min_pt:   16'd0,
    cone_radius_sq: 24'd106276,
    fraction_limit: 12'd26
  };

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic                    is_final;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
  } store_rec_t;

  typedef struct packed {
    logic            valid;
    logic [PT_W-1:0] pt;
  } hit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic logic [ETA_W-1:0] abs_eta(input logic signed [ETA_W-1:0] e);
    logic [ETA_W-1:0] u;
    u = e;
    return e[ETA_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic is_invisible(input logic [ID_W-1:0] id);
    return (id == ID_NU_E) || (id == ID_NU_MU) || (id == ID_NU_TAU) ||
           (id == ID_NEUTRALINO) || (id == ID_DM);
  endfunction

endpackage

// ----- src/cic_in_if.sv -----
// Input channel: particle load or candidate test beat.
interface cic_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic                             new_event;
  logic [cic_pkg::ID_W-1:0]         abs_id;
  logic                             is_final;
  logic [cic_pkg::PT_W-1:0]         pt;
  logic signed [cic_pkg::ETA_W-1:0] eta;
  logic [cic_pkg::PHI_W-1:0]        phi;
  logic [cic_pkg::IDX_W-1:0]        cand_index;

  modport source (
    output valid, op, new_event, abs_id, is_final, pt, eta, phi, cand_index,
    input  ready
  );

  modport sink (
    input  valid, op, new_event, abs_id, is_final, pt, eta, phi, cand_index,
    output ready
  );
endinterface

// ----- src/cic_out_if.sv -----
// Result channel: isolation verdict beat.
interface cic_out_if;
  logic                       valid;
  logic                       ready;
  logic                       isolated;
  logic                       cand_ok;
  logic [cic_pkg::SUM_W-1:0]  cone_sum;

  modport source (
    output valid, isolated, cand_ok, cone_sum,
    input  ready
  );

  modport sink (
    input  valid, isolated, cand_ok, cone_sum,
    output ready
  );
endinterface

// ----- src/cic_regs.sv -----
// APB configuration register bank.
module cic_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cic_pkg::ADDR_W-1:0]  paddr,
  input  logic [cic_pkg::DATA_W-1:0]  pwdata,
  output logic [cic_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cic_pkg::cfg_t               cfg
);
  import cic_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr;
  logic [REG_SEL_W-1:0] sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr) begin
      case (sel)
        REG_WANTED_ID:      cfg_r.wanted_id      <= pwdata[ID_W-1:0];
        REG_CAND_MIN_PT:    cfg_r.cand_min_pt    <= pwdata[PT_W-1:0];
        REG_CAND_MAX_ETA:   cfg_r.cand_max_eta   <= pwdata[CUT_W-1:0];
        REG_TRACK_MAX_ETA:  cfg_r.track_max_eta  <= pwdata[CUT_W-1:0];
        REG_TRACK_MIN_PT:   cfg_r.track_min_pt   <= pwdata[PT_W-1:0];
        REG_CONE_RADIUS_SQ: cfg_r.cone_radius_sq <= pwdata[RAD_W-1:0];
        REG_FRACTION_LIMIT: cfg_r.fraction_limit <= pwdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_WANTED_ID:      prdata = DATA_W'(cfg_r.wanted_id);
      REG_CAND_MIN_PT:    prdata = DATA_W'(cfg_r.cand_min_pt);
      REG_CAND_MAX_ETA:   prdata = DATA_W'(cfg_r.cand_max_eta);
      REG_TRACK_MAX_ETA:  prdata = DATA_W'(cfg_r.track_max_eta);
      REG_TRACK_MIN_PT:   prdata = DATA_W'(cfg_r.track_min_pt);
      REG_CONE_RADIUS_SQ: prdata = DATA_W'(cfg_r.cone_radius_sq);
      REG_FRACTION_LIMIT: prdata = DATA_W'(cfg_r.fraction_limit);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- src/cic_store.sv -----
// Event store: one write port, one registered read port.
module cic_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [cic_pkg::DEPTH_W-1:0]  waddr,
  input  cic_pkg::store_rec_t          wdata,
  input  logic                         re,
  input  logic [cic_pkg::DEPTH_W-1:0]  raddr,
  output cic_pkg::store_rec_t          rdata
);
  import cic_pkg::*;

  store_rec_t mem [EVENT_DEPTH];
  store_rec_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- src/cic_cone.sv -----
// Pipelined track cut and eta-phi distance unit, one stored particle per cycle.
module cic_cone (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [cic_pkg::DEPTH_W-1:0]  in_idx,
  input  cic_pkg::store_rec_t          rec,
  input  logic [cic_pkg::DEPTH_W-1:0]  cand_idx,
  input  logic signed [cic_pkg::ETA_W-1:0] ceta,
  input  logic [cic_pkg::PHI_W-1:0]    cphi,
  input  cic_pkg::cfg_t                cfg,
  output cic_pkg::hit_t                hit,
  output logic                         busy
);
  import cic_pkg::*;

  logic signed [DETA_W-1:0] deta;
  logic [DETA_W-1:0]        deta_u;
  logic [DETA_W-1:0]        adeta_full;
  logic [PHI_W-1:0]         dphi_raw;
  logic [PHI_W-1:0]         dphi;
  logic                     pass;
  logic [DETA_SQ_W-1:0]     deta_sq;
  logic [DPHI_SQ_W-1:0]     dphi_sq;
  logic [R2_W-1:0]          r2;

  logic                 v1_r, pass1_r;
  logic [ADETA_W-1:0]   adeta1_r;
  logic [PHI_W-1:0]     dphi1_r;
  logic [PT_W-1:0]      pt1_r;
  logic                 v2_r, pass2_r;
  logic [DETA_SQ_W-1:0] deta_sq2_r;
  logic [DPHI_SQ_W-1:0] dphi_sq2_r;
  logic [PT_W-1:0]      pt2_r;
  logic                 hit_v_r;
  logic [PT_W-1:0]      hit_pt_r;

  always_comb begin
    deta       = DETA_W'(rec.eta) - DETA_W'(ceta);
    deta_u     = deta;
    adeta_full = deta[DETA_W-1] ? (~deta_u + 1'b1) : deta_u;
    dphi_raw   = rec.phi - cphi;
    dphi       = (dphi_raw > PHI_HALF) ? (~dphi_raw + 1'b1) : dphi_raw;
    pass       = (in_idx != cand_idx) && rec.is_final && !is_invisible(rec.id) &&
                 (abs_eta(rec.eta) < ADETA_W'(cfg.track_max_eta)) &&
                 (rec.pt > cfg.track_min_pt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    pass1_r  <= pass;
    adeta1_r <= adeta_full[ADETA_W-1:0];
    dphi1_r  <= dphi;
    pt1_r    <= rec.pt;
  end

  assign deta_sq = adeta1_r * adeta1_r;
  assign dphi_sq = dphi1_r * dphi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pass2_r    <= pass1_r;
    deta_sq2_r <= deta_sq;
    dphi_sq2_r <= dphi_sq;
    pt2_r      <= pt1_r;
  end

  assign r2 = R2_W'(deta_sq2_r) + R2_W'(dphi_sq2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_v_r <= 1'b0;
    end else begin
      hit_v_r <= v2_r && pass2_r && (r2 < R2_W'(cfg.cone_radius_sq));
    end
    hit_pt_r <= pt2_r;
  end

  assign hit.valid = hit_v_r;
  assign hit.pt    = hit_pt_r;
  assign busy      = v1_r | v2_r;

endmodule

// ----- src/cone_isolation_check.sv -----
// Top level: event store, test sequencer and cone isolation result.
// A load beat writes one entry of the 256-deep event store; loads past the
// store depth are dropped. A test beat holds the input until its result is
// written; when the candidate passes its id and window cuts, the single read
// port of the store walks the event one entry per cycle into a three-stage
// distance unit, which is drained before the result is formed. A test of an
// index not loaded skips the store read, a failing one the scan. The result
// register frees the input side as soon as the result is written; loads keep
// flowing while a result waits to be taken. No clearing pass follows reset.
module cone_isolation_check (
  input  logic                        clk,
  input  logic                        rst_n,
  cic_in_if.sink                      in_ch,
  cic_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cic_pkg::ADDR_W-1:0]  paddr,
  input  logic [cic_pkg::DATA_W-1:0]  pwdata,
  output logic [cic_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import cic_pkg::*;

  cfg_t       cfg;
  store_rec_t wdata;
  store_rec_t rdata;
  hit_t       hit;
  logic       cone_busy;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [DEPTH_W-1:0]      cand_idx_r, cand_idx_nxt;
  logic [CNT_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic signed [ETA_W-1:0] ceta_r, ceta_nxt;
  logic [PHI_W-1:0]        cphi_r, cphi_nxt;
  logic [FPROD_W-1:0]      fprod_r, fprod_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    ok_r, ok_nxt;
  logic                    rd_v_r, rd_v_nxt;
  logic [DEPTH_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_iso_r, out_iso_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [SUM_W-1:0]        out_sum_r, out_sum_nxt;

  logic               in_acc;
  logic               we, re;
  logic [DEPTH_W-1:0] waddr, raddr;
  logic [CMP_W-1:0]   j_cmp;
  logic               in_range;
  logic               cand_pass;
  logic [SUM_W:0]     sum_ext;
  logic               out_free;

  cic_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cic_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  cic_cone u_cone (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_v_r),
    .in_idx   (rd_idx_r),
    .rec      (rdata),
    .cand_idx (cand_idx_r),
    .ceta     (ceta_r),
    .cphi     (cphi_r),
    .cfg      (cfg),
    .hit      (hit),
    .busy     (cone_busy)
  );

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid & in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.isolated = out_iso_r;
  assign out_ch.cand_ok  = out_ok_r;
  assign out_ch.cone_sum = out_sum_r;

  assign wdata.id       = in_ch.abs_id;
  assign wdata.is_final = in_ch.is_final;
  assign wdata.pt       = in_ch.pt;
  assign wdata.eta      = in_ch.eta;
  assign wdata.phi      = in_ch.phi;

  assign j_cmp     = CMP_W'(in_ch.cand_index);
  assign in_range  = j_cmp < CMP_W'(count_r);
  assign cand_pass = (rdata.id == cfg.wanted_id) && (rdata.pt > cfg.cand_min_pt) &&
                     (abs_eta(rdata.eta) < ETA_W'(cfg.cand_max_eta));
  assign sum_ext   = (SUM_W+1)'(sum_r) + (SUM_W+1)'(hit.pt);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_idx_r <= cand_idx_nxt;
    scan_idx_r <= scan_idx_nxt;
    ceta_r     <= ceta_nxt;
    cphi_r     <= cphi_nxt;
    fprod_r    <= fprod_nxt;
    sum_r      <= sum_nxt;
    ok_r       <= ok_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_iso_r  <= out_iso_nxt;
    out_ok_r   <= out_ok_nxt;
    out_sum_r  <= out_sum_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cand_idx_nxt = cand_idx_r;
    scan_idx_nxt = scan_idx_r;
    ceta_nxt     = ceta_r;
    cphi_nxt     = cphi_r;
    fprod_nxt    = fprod_r;
    sum_nxt      = sum_r;
    ok_nxt       = ok_r;
    rd_v_nxt     = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    out_iso_nxt  = out_iso_r;
    out_ok_nxt   = out_ok_r;
    out_sum_nxt  = out_sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we    = 1'b0;
    waddr = count_r[DEPTH_W-1:0];
    re    = 1'b0;
    raddr = j_cmp[DEPTH_W-1:0];

    if (hit.valid) begin
      sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OP_LOAD) begin
            if (in_ch.new_event) begin
              we        = 1'b1;
              waddr     = '0;
              count_nxt = CNT_W'(1);
            end else if (count_r < CNT_W'(EVENT_DEPTH)) begin
              we        = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else begin
            sum_nxt      = '0;
            ok_nxt       = 1'b0;
            cand_idx_nxt = j_cmp[DEPTH_W-1:0];
            if (in_range) begin
              re        = 1'b1;
              state_nxt = ST_CHECK;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_CHECK: begin
        ok_nxt       = cand_pass;
        ceta_nxt     = rdata.eta;
        cphi_nxt     = rdata.phi;
        fprod_nxt    = cfg.fraction_limit * rdata.pt;
        scan_idx_nxt = '0;
        state_nxt    = cand_pass ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        re           = 1'b1;
        raddr        = scan_idx_r[DEPTH_W-1:0];
        rd_v_nxt     = 1'b1;
        rd_idx_nxt   = scan_idx_r[DEPTH_W-1:0];
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_nxt == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !cone_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_sum_nxt   = sum_r;
          out_iso_nxt   = ok_r && ({sum_r, {FRAC_SHIFT{1'b0}}} < ISO_W'(fprod_r));
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/cone_isolation_check_tb.sv -----
// Self-checking testbench for the cone isolation check: loads events, tests candidates, checks verdicts.
module cone_isolation_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cic_pkg::*;

  typedef struct packed {
    logic                    op;
    logic                    new_event;
    logic [ID_W-1:0]         abs_id;
    logic                    is_final;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
    logic [IDX_W-1:0]        cand_index;
  } beat_t;

  typedef struct packed {
    logic             isolated;
    logic             cand_ok;
    logic [SUM_W-1:0] cone_sum;
  } verdict_t;

  class isolation_tracker;
    cfg_t        cuts;
    store_rec_t  event_rec[EVENT_DEPTH];
    int unsigned held;
    verdict_t    pending[$];
    int unsigned faults, loads, tests, passed, isolated_cnt;

    function new();
      cuts = CFG_RESET;
      held = 0;
      faults = 0;
      loads = 0;
      tests = 0;
      passed = 0;
      isolated_cnt = 0;
    endfunction

    function void set_reg(input logic [REG_SEL_W-1:0] sel, input logic [DATA_W-1:0] value);
      case (sel)
        REG_WANTED_ID:      cuts.wanted_id      = value[ID_W-1:0];
        REG_CAND_MIN_PT:    cuts.cand_min_pt    = value[PT_W-1:0];
        REG_CAND_MAX_ETA:   cuts.cand_max_eta   = value[CUT_W-1:0];
        REG_TRACK_MAX_ETA:  cuts.track_max_eta  = value[CUT_W-1:0];
        REG_TRACK_MIN_PT:   cuts.track_min_pt   = value[PT_W-1:0];
        REG_CONE_RADIUS_SQ: cuts.cone_radius_sq = value[RAD_W-1:0];
        REG_FRACTION_LIMIT: cuts.fraction_limit = value[FRAC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned mag(input int v);
      return (v < 0) ? int'(-v) : v;
    endfunction

    function bit hidden(input logic [ID_W-1:0] id);
      return id == ID_NU_E || id == ID_NU_MU || id == ID_NU_TAU ||
             id == ID_NEUTRALINO || id == ID_DM;
    endfunction

    function void take_beat(input beat_t b);
      verdict_t          v;
      store_rec_t        c;
      store_rec_t        r;
      int                ceta;
      int                deta;
      int unsigned       j;
      int unsigned       dphi;
      logic [PHI_W-1:0]  dp;
      longint unsigned   r2;
      longint unsigned   sum;
      if (b.op == OP_LOAD) begin
        loads++;
        if (b.new_event) held = 0;
        if (held < EVENT_DEPTH) begin
          event_rec[held] = '{id: b.abs_id, is_final: b.is_final, pt: b.pt,
                              eta: b.eta, phi: b.phi};
          held++;
        end
        return;
      end
      tests++;
      v = '0;
      j = b.cand_index;
      if (j < held) begin
        c = event_rec[j];
        ceta = $signed(c.eta);
        if (c.id == cuts.wanted_id && c.pt > cuts.cand_min_pt &&
            mag(ceta) < cuts.cand_max_eta) begin
          sum = 0;
          for (int unsigned i = 0; i < held; i++) begin
            r = event_rec[i];
            if (i == j || !r.is_final || hidden(r.id)) continue;
            if (mag($signed(r.eta)) >= cuts.track_max_eta || r.pt <= cuts.track_min_pt)
              continue;
            deta = $signed(r.eta) - ceta;
            dp = r.phi - c.phi;
            dphi = dp;
            if (dphi > 2048) dphi = 4096 - dphi;
            r2 = longint'(mag(deta)) * mag(deta) + longint'(dphi) * dphi;
            if (r2 < cuts.cone_radius_sq) begin
              sum += r.pt;
              if (sum > 64'hFF_FFFF) sum = 64'hFF_FFFF;
            end
          end
          v.cand_ok = 1'b1;
          v.cone_sum = sum[SUM_W-1:0];
          v.isolated = (sum * 256) < (longint'(cuts.fraction_limit) * c.pt);
        end
      end
      pending.push_back(v);
    endfunction

    function void report(input string field, input logic [SUM_W-1:0] want,
                         input logic [SUM_W-1:0] got);
      faults++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(input verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        faults++;
        $display("%0t: unexpected verdict isolated=%0d cand_ok=%0d cone_sum=%0d",
                 $time, got.isolated, got.cand_ok, got.cone_sum);
        return;
      end
      want = pending.pop_front();
      if (got.cand_ok === 1'b1) passed++;
      if (got.isolated === 1'b1) isolated_cnt++;
      if (got.isolated !== want.isolated)
        report("isolated", SUM_W'(want.isolated), SUM_W'(got.isolated));
      if (got.cand_ok !== want.cand_ok)
        report("cand_ok", SUM_W'(want.cand_ok), SUM_W'(got.cand_ok));
      if (got.cone_sum !== want.cone_sum)
        report("cone_sum", want.cone_sum, got.cone_sum);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cic_in_if  in_ch();
  cic_out_if out_ch();

  isolation_tracker iso;
  int unsigned      send_idle;
  int unsigned      recv_stall;

  cone_isolation_check i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      iso.check_result('{isolated: out_ch.isolated, cand_ok: out_ch.cand_ok,
                         cone_sum: out_ch.cone_sum});
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= b.op;
    in_ch.new_event  <= b.new_event;
    in_ch.abs_id     <= b.abs_id;
    in_ch.is_final   <= b.is_final;
    in_ch.pt         <= b.pt;
    in_ch.eta        <= b.eta;
    in_ch.phi        <= b.phi;
    in_ch.cand_index <= b.cand_index;
    do @(posedge clk); while (!in_ch.ready);
    iso.take_beat(b);
  endtask

  task automatic await_verdicts();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (iso.pending.size() != 0);
  endtask

  task automatic cfg_write(input logic [REG_SEL_W-1:0] sel, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    iso.set_reg(sel, value);
    @(posedge clk);
  endtask

  task automatic apply_cuts(input cfg_t c);
    await_verdicts();
    repeat (16) @(posedge clk);
    cfg_write(REG_WANTED_ID,      DATA_W'(c.wanted_id));
    cfg_write(REG_CAND_MIN_PT,    DATA_W'(c.cand_min_pt));
    cfg_write(REG_CAND_MAX_ETA,   DATA_W'(c.cand_max_eta));
    cfg_write(REG_TRACK_MAX_ETA,  DATA_W'(c.track_max_eta));
    cfg_write(REG_TRACK_MIN_PT,   DATA_W'(c.track_min_pt));
    cfg_write(REG_CONE_RADIUS_SQ, DATA_W'(c.cone_radius_sq));
    cfg_write(REG_FRACTION_LIMIT, DATA_W'(c.fraction_limit));
  endtask

  function automatic beat_t load_of(input bit fresh, input logic [ID_W-1:0] id, input bit fin,
                                    input logic [PT_W-1:0] pt, input int eta, input int phi);
    beat_t b;
    b.op         = OP_LOAD;
    b.new_event  = fresh;
    b.abs_id     = id;
    b.is_final   = fin;
    b.pt         = pt;
    b.eta        = ETA_W'(eta);
    b.phi        = PHI_W'(phi);
    b.cand_index = IDX_W'($urandom);
    return b;
  endfunction

  function automatic beat_t test_of(input int unsigned idx);
    beat_t b;
    b.op         = OP_TEST;
    b.new_event  = 1'($urandom);
    b.abs_id     = ID_W'($urandom);
    b.is_final   = 1'($urandom);
    b.pt         = PT_W'($urandom);
    b.eta        = ETA_W'($urandom);
    b.phi        = PHI_W'($urandom);
    b.cand_index = IDX_W'(idx);
    return b;
  endfunction

  function automatic beat_t random_particle(input int ceta, input logic [PHI_W-1:0] cphi);
    beat_t       b;
    int unsigned roll;
    b = test_of($urandom_range(255));
    b.op = OP_LOAD;
    b.new_event = 1'b0;
    roll = $urandom_range(99);
    if (roll < 35)      b.abs_id = iso.cuts.wanted_id;
    else if (roll < 45) b.abs_id = 24'd13;
    else if (roll < 52) b.abs_id = 24'd22;
    else if (roll < 67) begin
      case ($urandom_range(4))
        0:       b.abs_id = ID_NU_E;
        1:       b.abs_id = ID_NU_MU;
        2:       b.abs_id = ID_NU_TAU;
        3:       b.abs_id = ID_NEUTRALINO;
        default: b.abs_id = ID_DM;
      endcase
    end
    else if (roll < 77) b.abs_id = ID_W'($urandom);
    else                b.abs_id = ID_W'($urandom_range(30));
    b.is_final = ($urandom_range(99) < 85);
    roll = $urandom_range(99);
    if (roll < 3)       b.pt = '0;
    else if (roll < 13) b.pt = PT_W'($urandom);
    else                b.pt = PT_W'($urandom_range(4000, 1));
    if ($urandom_range(99) < 75) b.eta = ETA_W'(ceta + int'($urandom_range(800)) - 400);
    if ($urandom_range(99) < 75) b.phi = PHI_W'(int'(cphi) + int'($urandom_range(800)) - 400);
    return b;
  endfunction

  function automatic beat_t random_test();
    if (iso.held > 0 && $urandom_range(99) < 85)
      return test_of($urandom_range(iso.held - 1));
    return test_of($urandom_range(255));
  endfunction

  task automatic random_events(input int unsigned budget, input bit with_full);
    int unsigned      sent;
    int unsigned      n_load;
    int unsigned      n_test;
    int unsigned      roll;
    int               ceta;
    logic [PHI_W-1:0] cphi;
    beat_t            b;
    bit               full_pending;
    sent = 0;
    full_pending = with_full;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (full_pending)   n_load = $urandom_range(262, 257);
      else if (roll < 88) n_load = $urandom_range(20, 1);
      else if (roll < 98) n_load = $urandom_range(64, 21);
      else                n_load = $urandom_range(120, 65);
      full_pending = 1'b0;
      ceta = int'($urandom_range(3400)) - 1700;
      cphi = PHI_W'($urandom);
      for (int unsigned k = 0; k < n_load; k++) begin
        b = random_particle(ceta, cphi);
        if (k == 0) b.new_event = ($urandom_range(99) >= 4);
        else        b.new_event = ($urandom_range(199) == 0);
        send_beat(b);
        sent++;
        if ($urandom_range(99) < 6) begin
          send_beat(random_test());
          sent++;
        end
      end
      n_test = $urandom_range(5, 1);
      for (int unsigned k = 0; k < n_test; k++) begin
        send_beat(random_test());
        sent++;
      end
      if ($urandom_range(99) < 4) await_verdicts();
    end
  endtask

  initial begin
    iso = new();
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_LOAD;
    in_ch.new_event  = 1'b0;
    in_ch.abs_id     = '0;
    in_ch.is_final   = 1'b0;
    in_ch.pt         = '0;
    in_ch.eta        = '0;
    in_ch.phi        = '0;
    in_ch.cand_index = '0;
    out_ch.ready     = 1'b0;
    send_idle        = 0;
    recv_stall       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(test_of(0));
    send_beat(load_of(1, 24'd11, 1, 16'd1000, 0, 5));
    send_beat(load_of(0, 24'd13, 1, 16'd500, 100, 4090));
    send_beat(load_of(0, ID_NU_E, 1, 16'd700, 10, 10));
    send_beat(load_of(0, ID_NU_MU, 1, 16'd700, 10, 10));
    send_beat(load_of(0, ID_NU_TAU, 1, 16'd700, 10, 10));
    send_beat(load_of(0, ID_NEUTRALINO, 1, 16'd700, 10, 10));
    send_beat(load_of(0, ID_DM, 1, 16'd700, 10, 10));
    send_beat(load_of(0, 24'd22, 0, 16'd300, 0, 0));
    send_beat(load_of(0, 24'd211, 1, 16'hFFFF, -4096, 2048));
    send_beat(load_of(0, 24'd211, 1, 16'd0, 4095, 4095));
    send_beat(load_of(0, 24'd211, 1, 16'd40, 0, 2053));
    send_beat(load_of(0, 24'hFF_FFFF, 1, 16'hFFFF, 50, 30));
    send_beat(load_of(0, 24'd11, 1, 16'd200, 326, 5));
    send_beat(load_of(0, 24'd11, 1, 16'd200, 325, 5));
    send_beat(test_of(0));
    send_beat(test_of(1));
    send_beat(test_of(14));
    send_beat(test_of(200));
    send_beat(load_of(1, 24'd11, 1, 16'd1, -1629, 100));
    send_beat(load_of(0, 24'd11, 1, 16'd64, 1630, 100));
    send_beat(test_of(0));
    send_beat(test_of(1));
    send_beat(load_of(1, 24'd11, 1, 16'd6400, 0, 0));
    send_beat(load_of(0, 24'd13, 1, 16'd10, 20, 20));
    send_beat(test_of(0));

    apply_cuts('{wanted_id: 24'd13, cand_min_pt: 16'd64, cand_max_eta: 12'd2000,
                 track_max_eta: 12'd4095, track_min_pt: 16'd0,
                 cone_radius_sq: 24'd250000, fraction_limit: 12'd4095});
    send_idle = 0;
    recv_stall = 0;
    random_events(100, 1'b0);

    apply_cuts('{wanted_id: 24'd22, cand_min_pt: 16'd0, cand_max_eta: 12'd4095,
                 track_max_eta: 12'd1000, track_min_pt: 16'd500,
                 cone_radius_sq: 24'hFF_FFFF, fraction_limit: 12'd0});
    send_idle = 47;
    recv_stall = 0;
    random_events(100, 1'b0);

    apply_cuts('{wanted_id: 24'hFF_FFFF, cand_min_pt: 16'd1000, cand_max_eta: 12'd1000,
                 track_max_eta: 12'd2500, track_min_pt: 16'd2000,
                 cone_radius_sq: 24'd1, fraction_limit: 12'd1});
    send_idle = 0;
    recv_stall = 47;
    random_events(100, 1'b0);

    apply_cuts(CFG_RESET);
    send_idle = 19;
    recv_stall = 19;
    random_events(280, 1'b1);

    apply_cuts('{wanted_id: 24'd0, cand_min_pt: 16'hFFFF, cand_max_eta: 12'd0,
                 track_max_eta: 12'd0, track_min_pt: 16'hFFFF,
                 cone_radius_sq: 24'd0, fraction_limit: 12'hFFF});
    send_idle = 0;
    recv_stall = 0;
    random_events(20, 1'b0);
    apply_cuts('{wanted_id: 24'd0, cand_min_pt: 16'd0, cand_max_eta: 12'hFFF,
                 track_max_eta: 12'hFFF, track_min_pt: 16'd0,
                 cone_radius_sq: 24'd0, fraction_limit: 12'hFFF});
    random_events(20, 1'b0);

    await_verdicts();
    repeat (40) @(posedge clk);
    $display("Covered %0d particle loads and %0d candidate tests over six cut settings,",
             iso.loads, iso.tests);
    $display("with %0d candidates passing their cuts and %0d found isolated.",
             iso.passed, iso.isolated_cnt);
    if (iso.faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
